[design/rmsm_pkg.sv]
`default_nettype none
package rmsm_pkg;
  localparam int MaxChannelsDef = 16;
  localparam int SumW = 32;
  localparam int AmpsW = 24;
  localparam int WinW = 10;
  localparam int RootW = 24;

  localparam logic [1:0] CfgChannelCount = 2'd0;
  localparam logic [1:0] CfgWindowLength = 2'd1;
  localparam logic [1:0] CfgAdcMidpoint = 2'd2;
  localparam logic [1:0] CfgAmpsPerCount = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACC_RD, ST_ACC_WR, ST_EM_RD, ST_EM_LD, ST_EM_DIV, ST_EM_SQRT,
    ST_EM_MUL, ST_EM_OUT, ST_EM_CLR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_sample;
    logic acc_rd;
    logic acc_wr;
    logic em_rd;
    logic div_start;
    logic sqrt_start;
    logic mul_go;
    logic out_load;
    logic clr_wr;
    logic chan_inc;
    logic chan_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic chan_is_last;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

[design/rmsm_ram.sv]
`default_nettype none
module rmsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/rmsm_ctrl.sv]
`default_nettype none
module rmsm_ctrl
  import rmsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic window_end,
  input  wire sts_t sts,
  output logic      in_ready,
  output cmd_t      cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_ACC_RD;
      ST_ACC_RD:  state_nxt = ST_ACC_WR;
      ST_ACC_WR:  state_nxt = window_end ? ST_EM_RD : ST_IDLE;
      ST_EM_RD:   state_nxt = ST_EM_LD;
      ST_EM_LD:   state_nxt = ST_EM_DIV;
      ST_EM_DIV:  if (sts.div_done) state_nxt = ST_EM_SQRT;
      ST_EM_SQRT: if (sts.sqrt_done) state_nxt = ST_EM_MUL;
      ST_EM_MUL:  state_nxt = ST_EM_OUT;
      ST_EM_OUT:  if (!sts.out_busy) state_nxt = ST_EM_CLR;
      ST_EM_CLR:  state_nxt = sts.chan_is_last ? ST_IDLE : ST_EM_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load_sample = in_fire;
        cmd.chan_clear = 1'b1;
      end
      ST_ACC_RD:  cmd.acc_rd = 1'b1;
      ST_ACC_WR:  cmd.acc_wr = 1'b1;
      ST_EM_RD:   cmd.em_rd = 1'b1;
      // sum is on the read port now
      ST_EM_LD:   cmd.div_start = 1'b1;
      ST_EM_DIV:  cmd.sqrt_start = sts.div_done;
      ST_EM_SQRT: ;
      ST_EM_MUL:  cmd.mul_go = 1'b1;
      ST_EM_OUT:  cmd.out_load = !sts.out_busy;
      ST_EM_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.chan_inc = 1'b1;
      end
      default: ;
    endcase
  end

  // accumulation always followed by write-back
  a_acc_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC_RD |=> state_r == ST_ACC_WR)
    else $error("read without write-back");
  // no input taken outside idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  // each result is cleared after output
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_wr |-> $past(state_r) == ST_EM_OUT)
    else $error("clear out of order");
endmodule
`default_nettype wire

[design/rmsm_dpath.sv]
`default_nettype none
module rmsm_dpath
  import rmsm_pkg::*;
#(
  parameter int MaxChannels = MaxChannelsDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic [3:0]       in_channel,
  input  wire logic [9:0]       in_adc_value,
  input  wire logic [4:0]       cfg_count,
  input  wire logic [WinW-1:0]  cfg_window,
  input  wire logic [9:0]       cfg_mid,
  input  wire logic [23:0]      cfg_apc,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output logic [3:0]            out_channel,
  output logic [AmpsW-1:0]      out_amps,
  output logic                  out_last,
  output logic                  window_end,
  output sts_t                  sts
);
  localparam int AW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int NMax = (MaxChannels > 16) ? 16 : MaxChannels;

  // active channel count and window length
  logic [4:0] n_act;
  logic [WinW-1:0] wl;
  always_comb begin
    n_act = (cfg_count == 5'd0) ? 5'd1 : cfg_count;
    if (n_act > 5'(NMax)) n_act = 5'(NMax);
    wl = (cfg_window == '0) ? WinW'(1) : cfg_window;
  end

  // sample capture and square
  logic [3:0] ch_r;
  logic [19:0] sq_r;
  logic take_r;
  logic [10:0] diff;
  logic [9:0] mag;
  assign diff = {1'b0, in_adc_value} - {1'b0, cfg_mid};
  assign mag = diff[10] ? 10'(-diff) : diff[9:0];
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      ch_r <= in_channel;
      sq_r <= mag * mag;
      take_r <= ({1'b0, in_channel} < n_act);
    end
  end

  // frame counter and emit channel index
  logic [WinW-1:0] frame_r;
  logic [3:0] ech_r;
  logic is_frame_end;
  logic [WinW-1:0] frame_inc;
  assign is_frame_end = take_r && ({1'b0, ch_r} == n_act - 5'd1);
  assign frame_inc = frame_r + WinW'(1);
  assign window_end = cmd.acc_wr && is_frame_end &&
                      (frame_inc >= wl || frame_inc == '0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (cmd.acc_wr && is_frame_end) begin
      frame_r <= window_end ? '0 : frame_inc;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.chan_clear) ech_r <= '0;
    else if (cmd.chan_inc) ech_r <= ech_r + 4'd1;
  end
  assign sts.chan_is_last = ({1'b0, ech_r} == n_act - 5'd1);

  // sums read as zero until written; all marks dropped at the last channel's clear
  logic [MaxChannels-1:0] vld_r;
  logic [AW-1:0] raddr, waddr;
  logic [SumW-1:0] rdata, wdata;
  logic we;
  logic rd_vld_r;
  assign raddr = cmd.em_rd ? AW'(ech_r) : AW'(ch_r);
  assign waddr = cmd.clr_wr ? AW'(ech_r) : AW'(ch_r);
  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[raddr];
  end
  logic [SumW-1:0] sum_cur;
  assign sum_cur = rd_vld_r ? rdata : '0;
  assign we = (cmd.acc_wr && take_r) || cmd.clr_wr;
  assign wdata = cmd.clr_wr ? '0 : sum_cur + SumW'(sq_r);
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (cmd.clr_wr && sts.chan_is_last) vld_r <= '0;
    else if (we) vld_r[waddr] <= 1'b1;
  end

  rmsm_ram #(.Width(SumW), .Depth(MaxChannels)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // restoring divider: sum / wl, one quotient bit a cycle
  logic [SumW-1:0] dvd_r;
  logic [SumW-1:0] q_r;
  logic [WinW:0] rm_r;
  logic [WinW:0] rt;
  logic [5:0] dcnt_r;
  logic dbusy_r;
  assign rt = {rm_r[WinW-1:0], dvd_r[SumW-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && dcnt_r == 6'(SumW - 1)) begin
      dbusy_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r <= sum_cur;
      rm_r <= '0;
      q_r <= '0;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r + 6'd1;
      dvd_r <= {dvd_r[SumW-2:0], 1'b0};
      if (rt >= {1'b0, wl}) begin
        rm_r <= rt - {1'b0, wl};
        q_r <= {q_r[SumW-2:0], 1'b1};
      end else begin
        rm_r <= rt;
        q_r <= {q_r[SumW-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = dbusy_r && dcnt_r == 6'(SumW - 1);

  // bit-pair square root of (mean << 16), 48-bit radicand
  localparam int RadW = SumW + 16;
  logic [RadW-1:0] rad_r;
  logic [RootW+1:0] srem_r;
  logic [RootW-1:0] root_r;
  logic [4:0] scnt_r;
  logic sbusy_r;
  logic [RootW+1:0] stry, sacc;
  assign sacc = {srem_r[RootW-1:0], rad_r[RadW-1 -: 2]};
  assign stry = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sbusy_r <= 1'b1;
    end else if (sbusy_r && scnt_r == 5'(RootW - 1)) begin
      sbusy_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rad_r <= {q_r[SumW-2:0], (rt >= {1'b0, wl}), 16'd0};
      srem_r <= '0;
      root_r <= '0;
      scnt_r <= '0;
    end else if (sbusy_r) begin
      scnt_r <= scnt_r + 5'd1;
      rad_r <= {rad_r[RadW-3:0], 2'b00};
      if (sacc >= stry) begin
        srem_r <= sacc - stry;
        root_r <= {root_r[RootW-2:0], 1'b1};
      end else begin
        srem_r <= sacc;
        root_r <= {root_r[RootW-2:0], 1'b0};
      end
    end
  end
  assign sts.sqrt_done = sbusy_r && scnt_r == 5'(RootW - 1);

  // scale and saturate
  logic [47:0] prod_r;
  always_ff @(posedge clk) begin
    if (cmd.mul_go) prod_r <= root_r * cfg_apc;
  end
  logic [AmpsW-1:0] amps_sat;
  assign amps_sat = (prod_r[47:40] != '0) ? '1 : prod_r[39:16];

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel <= ech_r;
      out_amps <= amps_sat;
      out_last <= sts.chan_is_last;
    end
  end
  assign sts.out_busy = out_tvalid && !out_tready;

  // divider and root never run together
  a_units: assert property (@(posedge clk) disable iff (!rst_n)
    !(dbusy_r && sbusy_r)) else $error("units overlap");
  // frame counter cleared after window end
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    window_end |=> frame_r == '0) else $error("frame counter kept");
  // a held result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy) else $error("result overwritten");
endmodule
`default_nettype wire

[design/multichannel_rms_current_meter.sv]
`default_nettype none
// RMS current meter over up to 16 channels. Each sample transfer carries a channel
// and a 10-bit code; the midpoint is removed, the square added to that channel's
// 32-bit sum (capture, sum read, write-back). After window_length frames one
// result per active channel is sent in channel order, each going through sum read
// and load, a divider by window_length, a square root, a multiply, output load and
// clear, plus any output stall; no samples are taken during this phase.
module multichannel_rms_current_meter
  import rmsm_pkg::*;
#(
  parameter int MaxChannels = MaxChannelsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [3:0] channel, [13:4] adc_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [3:0] channel_out, [27:4] amps_q8
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  logic [4:0] cc_r;
  logic [WinW-1:0] wl_r;
  logic [9:0] mid_r;
  logic [23:0] apc_r;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= 5'd9;
      wl_r <= 10'd500;
      mid_r <= 10'd512;
      apc_r <= 24'd4848;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgChannelCount: cc_r <= cfg_data[4:0];
        CfgWindowLength: wl_r <= cfg_data[9:0];
        CfgAdcMidpoint:  mid_r <= cfg_data[9:0];
        CfgAmpsPerCount: apc_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  sts_t sts;
  logic window_end;
  logic [3:0] och;
  logic [AmpsW-1:0] oamp;

  rmsm_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && in_tready), .window_end, .sts,
    .in_ready(in_tready), .cmd
  );

  rmsm_dpath #(.MaxChannels(MaxChannels)) u_dp (
    .clk, .rst_n, .cmd, .in_channel(in_tdata[3:0]), .in_adc_value(in_tdata[13:4]),
    .cfg_count(cc_r), .cfg_window(wl_r), .cfg_mid(mid_r), .cfg_apc(apc_r),
    .out_tready, .out_tvalid, .out_channel(och), .out_amps(oamp),
    .out_last(out_tlast), .window_end, .sts
  );

  assign out_tdata = {4'd0, oamp, och};
endmodule
`default_nettype wire
